### rtl/afgb_pkg.sv
package afgb_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COEF_W        = 32;
    localparam int MAT_COEFS     = 16;
    localparam int STORE_DEPTH   = 32;
    localparam int CODE_W        = 6;
    localparam int FIELD_W       = 24;
    localparam int S_TDATA_W     = 232;
    localparam int S_TUSER_W     = 2;
    localparam int M_TDATA_W     = 96;
    localparam int M_TUSER_W     = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_REJECT = 2'd0,
        VERDICT_INSIDE = 2'd1,
        VERDICT_GUARD  = 2'd2,
        VERDICT_CLIP   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [FIELD_W-1:0] near_codes;
        logic [FIELD_W-1:0] far_codes;
    } code_pair_t;

endpackage

### rtl/afgb_xform.sv
module afgb_xform #(
    parameter int FRAC_BITS = afgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [afgb_pkg::COEF_W-1:0]     mat [afgb_pkg::MAT_COEFS],
    input  logic signed [afgb_pkg::COEF_W-1:0]     lo  [3],
    input  logic signed [afgb_pkg::COEF_W-1:0]     hi  [3],
    output logic signed [2*afgb_pkg::COEF_W-FRAC_BITS+1:0] clip [2][4][4]
);
    import afgb_pkg::*;

    localparam int PW = 2 * COEF_W - FRAC_BITS;
    localparam int SW = PW + 2;

    // stage 1: floored products, stage 2: partial sums, stage 3: full sums
    logic signed [PW-1:0]     px_reg  [4][2];
    logic signed [PW-1:0]     py_reg  [4][2];
    logic signed [PW-1:0]     pz_reg  [4][2];
    logic signed [COEF_W-1:0] mt_reg  [4];
    logic signed [SW-1:0]     pxy_reg [4][4];
    logic signed [SW-1:0]     pzm_reg [4][2];
    logic signed [SW-1:0]     c_reg   [2][4][4];

    logic signed [2*COEF_W-1:0] px_next [4][2];
    logic signed [2*COEF_W-1:0] py_next [4][2];
    logic signed [2*COEF_W-1:0] pz_next [4][2];

    always_comb begin
        for (int col = 0; col < 4; col++) begin
            px_next[col][0] = mat[col] * lo[0];
            px_next[col][1] = mat[col] * hi[0];
            py_next[col][0] = mat[4+col] * lo[1];
            py_next[col][1] = mat[4+col] * hi[1];
            pz_next[col][0] = mat[8+col] * lo[2];
            pz_next[col][1] = mat[8+col] * hi[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int col = 0; col < 4; col++) begin
                for (int s = 0; s < 2; s++) begin
                    px_reg[col][s] <= px_next[col][s][2*COEF_W-1:FRAC_BITS];
                    py_reg[col][s] <= py_next[col][s][2*COEF_W-1:FRAC_BITS];
                    pz_reg[col][s] <= pz_next[col][s][2*COEF_W-1:FRAC_BITS];
                    pzm_reg[col][s] <= SW'(pz_reg[col][s]) + SW'(mt_reg[col]);
                end
                mt_reg[col] <= mat[12+col];
                for (int k = 0; k < 4; k++) begin
                    pxy_reg[col][k] <= SW'(px_reg[col][k%2]) + SW'(py_reg[col][k/2]);
                    for (int zs = 0; zs < 2; zs++) begin
                        c_reg[zs][k][col] <= pxy_reg[col][k] + pzm_reg[col][zs];
                    end
                end
            end
        end
    end

    assign clip = c_reg;

endmodule

### rtl/afgb_class.sv
module afgb_class #(
    parameter int FRAC_BITS = afgb_pkg::FRAC_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           en,
    input  logic signed [2*afgb_pkg::COEF_W-FRAC_BITS+1:0] clip [2][4][4],
    output afgb_pkg::code_pair_t                           codes
);
    import afgb_pkg::*;

    localparam int SW = 2 * COEF_W - FRAC_BITS + 2;

    code_pair_t codes_reg;
    code_pair_t codes_next;
    logic [CODE_W-1:0]  oc [2][4];
    logic signed [SW:0] nsum [2][4][3];

    always_comb begin
        for (int zs = 0; zs < 2; zs++) begin
            for (int k = 0; k < 4; k++) begin
                for (int a = 0; a < 3; a++) begin
                    nsum[zs][k][a] = (SW+1)'(clip[zs][k][a]) + (SW+1)'(clip[zs][k][3]);
                    oc[zs][k][2*a]   = clip[zs][k][a] > clip[zs][k][3];
                    oc[zs][k][2*a+1] = nsum[zs][k][a][SW];
                end
            end
        end
        for (int k = 0; k < 4; k++) begin
            codes_next.near_codes[(3-k)*CODE_W +: CODE_W] = oc[0][k];
            codes_next.far_codes[(3-k)*CODE_W +: CODE_W]  = oc[1][k];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            codes_reg <= codes_next;
        end
    end

    assign codes = codes_reg;

endmodule

### rtl/aabb_frustum_guard_band_cull.sv
// Box-against-frustum cull with guard band.
// Slave channel carries requests: s_tuser[0] picks load (0) or test (1).
// A load writes one coefficient of the screen or guard-band matrix and
// yields no result; it takes effect for every test accepted after it.
// A test carries a box (min and max corners) and yields one result on the
// master channel: verdict in m_tuser, four 24-bit outcode fields in m_tdata.
// Requests pass through five register stages (multiply, partial sum, sum,
// outcode, verdict) that all advance together. One request per cycle is
// taken while no result is stalled, so throughput is set by the pipeline at
// one box per clock.
// When m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears both matrices to zero and empties
// the pipeline.
module aabb_frustum_guard_band_cull #(
    parameter int FRAC_BITS = afgb_pkg::FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // coef_index[3:0], coef_value[35:4], min_x[67:36], min_y[99:68],
    // min_z[131:100], max_x[163:132], max_y[195:164], max_z[227:196]
    input  logic [afgb_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[0], matrix_select[1]
    input  logic [afgb_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // screen_codes_near[23:0], screen_codes_far[47:24],
    // guard_codes_near[71:48], guard_codes_far[95:72]
    output logic [afgb_pkg::M_TDATA_W-1:0]   m_tdata,
    // verdict[1:0]
    output logic [afgb_pkg::M_TUSER_W-1:0]   m_tuser
);
    import afgb_pkg::*;

    localparam int SW = 2 * COEF_W - FRAC_BITS + 2;

    logic                     en;
    logic                     accept;
    logic [COEF_W-1:0]        mat_reg [STORE_DEPTH];
    logic signed [COEF_W-1:0] scr_mat [MAT_COEFS];
    logic signed [COEF_W-1:0] grd_mat [MAT_COEFS];
    logic signed [COEF_W-1:0] lo [3];
    logic signed [COEF_W-1:0] hi [3];
    logic signed [SW-1:0]     scr_clip [2][4][4];
    logic signed [SW-1:0]     grd_clip [2][4][4];
    code_pair_t               scr_codes;
    code_pair_t               grd_codes;
    logic [3:0]               vld_reg;
    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TDATA_W-1:0]     m_tdata_next;
    verdict_t                 verdict_reg;
    verdict_t                 verdict_next;
    logic [CODE_W-1:0]        all_and;
    logic                     reject;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_DEPTH; i++) begin
                mat_reg[i] <= '0;
            end
        end else if (accept && s_tuser[0] == REQ_LOAD) begin
            mat_reg[{s_tuser[1], s_tdata[3:0]}] <= s_tdata[35:4];
        end
    end

    always_comb begin
        for (int i = 0; i < MAT_COEFS; i++) begin
            scr_mat[i] = mat_reg[i];
            grd_mat[i] = mat_reg[MAT_COEFS+i];
        end
        for (int a = 0; a < 3; a++) begin
            lo[a] = s_tdata[36 + a*COEF_W +: COEF_W];
            hi[a] = s_tdata[36 + (a+3)*COEF_W +: COEF_W];
        end
    end

    afgb_xform #(.FRAC_BITS(FRAC_BITS)) u_scr_xform (
        .aclk(aclk), .en(en), .mat(scr_mat), .lo(lo), .hi(hi), .clip(scr_clip)
    );

    afgb_xform #(.FRAC_BITS(FRAC_BITS)) u_grd_xform (
        .aclk(aclk), .en(en), .mat(grd_mat), .lo(lo), .hi(hi), .clip(grd_clip)
    );

    afgb_class #(.FRAC_BITS(FRAC_BITS)) u_scr_class (
        .aclk(aclk), .en(en), .clip(scr_clip), .codes(scr_codes)
    );

    afgb_class #(.FRAC_BITS(FRAC_BITS)) u_grd_class (
        .aclk(aclk), .en(en), .clip(grd_clip), .codes(grd_codes)
    );

    always_comb begin
        all_and = '1;
        for (int k = 0; k < 4; k++) begin
            all_and = all_and & scr_codes.near_codes[k*CODE_W +: CODE_W]
                              & scr_codes.far_codes[k*CODE_W +: CODE_W];
        end
        reject = (all_and[1] ^ all_and[0]) || (all_and[3] ^ all_and[2])
              || (all_and[5] ^ all_and[4]);
        m_tdata_next = {FIELD_W'(0), FIELD_W'(0), scr_codes.far_codes,
                        scr_codes.near_codes};
        if (reject) begin
            verdict_next = VERDICT_REJECT;
        end else if ((scr_codes.near_codes | scr_codes.far_codes) == '0) begin
            verdict_next = VERDICT_INSIDE;
        end else begin
            m_tdata_next = {grd_codes.far_codes, grd_codes.near_codes,
                            scr_codes.far_codes, scr_codes.near_codes};
            if ((grd_codes.near_codes | grd_codes.far_codes) == '0) begin
                verdict_next = VERDICT_GUARD;
            end else begin
                verdict_next = VERDICT_CLIP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= {vld_reg[2:0], s_tvalid && s_tuser[0] == REQ_TEST};
            m_tvalid_reg <= vld_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= m_tdata_next;
            verdict_reg <= verdict_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = verdict_reg;

endmodule

### rtl/afgb_checker.sv
module afgb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [afgb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [afgb_pkg::M_TUSER_W-1:0] m_tuser
);
    import afgb_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_inside_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == VERDICT_INSIDE |-> m_tdata == '0)
        else $error("inside verdict with out flags");

    a_guard_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == VERDICT_REJECT || m_tuser == VERDICT_GUARD)
        |-> m_tdata[M_TDATA_W-1:2*FIELD_W] == '0)
        else $error("guard codes set for reject or guard verdict");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while result stalled");

endmodule

bind aabb_frustum_guard_band_cull afgb_checker u_afgb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

### dv/tb_aabb_frustum_guard_band_cull.sv
module tb_aabb_frustum_guard_band_cull;
    import afgb_pkg::*;

    localparam int FB = FRAC_BITS_DEF;

    typedef struct {
        verdict_t        verdict;
        logic [23:0]     sn;
        logic [23:0]     sf;
        logic [23:0]     gn;
        logic [23:0]     gf;
    } cull_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int errors = 0;

    aabb_frustum_guard_band_cull uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        errors++;
    endtask

    class cull_scoreboard;
        logic [31:0]  coefs [32];
        cull_result_t pending [$];

        function new();
            foreach (coefs[i]) coefs[i] = '0;
        endfunction

        function longint fmul(longint a, longint b);
            return (a * b) >>> FB;
        endfunction

        function logic [5:0] outcode(int base, longint x, longint y, longint z);
            longint m [16];
            longint c [4];
            logic [5:0] f;
            f = '0;
            for (int i = 0; i < 16; i++) m[i] = longint'($signed(coefs[base + i]));
            for (int i = 0; i < 4; i++)
                c[i] = fmul(m[i], x) + fmul(m[4+i], y) + fmul(m[8+i], z) + m[12+i];
            f[0] = c[0] > c[3];
            f[1] = c[0] < -c[3];
            f[2] = c[1] > c[3];
            f[3] = c[1] < -c[3];
            f[4] = c[2] > c[3];
            f[5] = c[2] < -c[3];
            return f;
        endfunction

        function logic [23:0] quad(int base, longint lx, longint ly, longint hx, longint hy,
                                   longint z);
            return {outcode(base, lx, ly, z), outcode(base, hx, ly, z),
                    outcode(base, lx, hy, z), outcode(base, hx, hy, z)};
        endfunction

        function void note_request(logic [S_TUSER_W-1:0] u, logic [S_TDATA_W-1:0] d);
            cull_result_t r;
            longint lx, ly, lz, hx, hy, hz;
            logic [23:0] a;
            logic [5:0] v;
            if (u[0] == REQ_LOAD) begin
                coefs[{u[1], d[3:0]}] = d[35:4];
                return;
            end
            lx = longint'($signed(d[67:36]));
            ly = longint'($signed(d[99:68]));
            lz = longint'($signed(d[131:100]));
            hx = longint'($signed(d[163:132]));
            hy = longint'($signed(d[195:164]));
            hz = longint'($signed(d[227:196]));
            r.sn = quad(0, lx, ly, hx, hy, lz);
            r.sf = quad(0, lx, ly, hx, hy, hz);
            r.gn = '0;
            r.gf = '0;
            a = r.sn & r.sf;
            v = a[23:18] & a[17:12] & a[11:6] & a[5:0];
            if (((v ^ (v << 1)) & 6'h2A) != 0) r.verdict = VERDICT_REJECT;
            else if ((r.sn | r.sf) == 0) r.verdict = VERDICT_INSIDE;
            else begin
                r.gn = quad(16, lx, ly, hx, hy, lz);
                r.gf = quad(16, lx, ly, hx, hy, hz);
                r.verdict = ((r.gn | r.gf) == 0) ? VERDICT_GUARD : VERDICT_CLIP;
            end
            pending.push_back(r);
        endfunction

        task check_result(logic [M_TUSER_W-1:0] u, logic [M_TDATA_W-1:0] d);
            cull_result_t r;
            if (pending.size() == 0) begin
                report("unexpected result", {30'b0, u}, 0);
                return;
            end
            r = pending.pop_front();
            if (u != r.verdict) report("verdict", {30'b0, u}, {30'b0, r.verdict});
            if (d[23:0] != r.sn) report("screen_codes_near", {8'b0, d[23:0]}, {8'b0, r.sn});
            if (d[47:24] != r.sf) report("screen_codes_far", {8'b0, d[47:24]}, {8'b0, r.sf});
            if (d[71:48] != r.gn) report("guard_codes_near", {8'b0, d[71:48]}, {8'b0, r.gn});
            if (d[95:72] != r.gf) report("guard_codes_far", {8'b0, d[95:72]}, {8'b0, r.gf});
        endtask
    endclass

    cull_scoreboard sb = new();
    logic [31:0] boxv [6];
    bit no_gaps = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    initial begin
        m_tready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            int w;
            w = no_gaps ? 0 : $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk iff m_tvalid);
        end
    end

    task automatic send(input logic [S_TUSER_W-1:0] u, input logic [S_TDATA_W-1:0] d);
        int w;
        w = no_gaps ? 0 : $urandom_range(0, 18);
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= u;
        s_tdata <= d;
        @(posedge aclk iff s_tready);
    endtask

    task automatic load_coef(input bit sel, input logic [3:0] idx, input logic [31:0] val);
        logic [S_TDATA_W-1:0] d;
        d = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom});
        d[3:0] = idx;
        d[35:4] = val;
        d[S_TDATA_W-1:228] = '0;
        send({sel, REQ_LOAD}, d);
    endtask

    task automatic test_box();
        logic [S_TDATA_W-1:0] d;
        d = '0;
        d[3:0] = 4'($urandom);
        d[35:4] = $urandom;
        for (int i = 0; i < 6; i++) d[36 + 32*i +: 32] = boxv[i];
        send({1'($urandom), REQ_TEST}, d);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            default: return ($urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000);
        endcase
    endfunction

    task automatic random_box(int mode);
        for (int i = 0; i < 6; i++) boxv[i] = rand_coord($urandom_range(0, 9) == 0 ? 2 : mode);
        if (mode == 1 && $urandom_range(0, 3) != 0)
            for (int i = 0; i < 3; i++)
                if ($signed(boxv[i]) > $signed(boxv[3+i])) begin
                    logic [31:0] t;
                    t = boxv[i];
                    boxv[i] = boxv[3+i];
                    boxv[3+i] = t;
                end
    endtask

    // identity-like projection scaled by s, w row from m15
    task automatic load_frustum(input bit sel, input int s);
        for (int i = 0; i < 16; i++)
            load_coef(sel, i[3:0], (i % 5 == 0) ? (i == 15 ? 32'(1 << FB) : 32'(s)) : 32'h0);
    endtask

    task automatic wait_drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // all-zero matrices
        boxv = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                 32'h7FFFFFFF};
        test_box();
        load_frustum(0, 1 << FB);
        load_frustum(1, 1 << (FB - 2));
        boxv = '{32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000, 32'h8000, 32'h8000, 32'h8000};
        test_box();
        boxv = '{32'h30000, 32'h0, 32'h0, 32'h40000, 32'h8000, 32'h8000};
        test_box();
        boxv = '{32'hFFFE0000, 32'hFFFE0000, 32'h0, 32'h20000, 32'h20000, 32'h8000};
        test_box();
        boxv = '{32'hFFF00000, 32'hFFF00000, 32'hFFF00000, 32'h100000, 32'h100000,
                 32'h100000};
        test_box();
        boxv = '{32'h8000, 32'h8000, 32'h8000, 32'hFFFF8000, 32'hFFFF8000, 32'hFFFF8000};
        test_box();
        load_coef(1, 4'd15, 32'h80000000);
        load_coef(0, 4'd7, 32'h7FFFFFFF);
        boxv = '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000};
        test_box();
        load_coef(0, 4'd7, 32'h0);
        load_coef(1, 4'd15, 32'h00010000);

        for (int n = 0; n < 260; n++) begin
            int r;
            r = $urandom_range(0, 99);
            if (n == 150) begin
                wait_drain();
                no_gaps = 1;
            end
            if (n == 200) no_gaps = 0;
            if (r < 4) load_frustum(1'($urandom_range(0, 1)),
                                    $urandom_range(1 << (FB - 3), 4 << FB));
            else if (r < 12) load_coef(1'($urandom_range(0, 1)), 4'($urandom), $urandom);
            else if (r < 15) load_coef(1'($urandom_range(0, 1)), 4'($urandom),
                                       32'($signed($urandom_range(0, 4 << FB)) - (2 << FB)));
            else begin
                random_box(r < 85 ? 1 : 0);
                test_box();
            end
        end
        wait_drain();
        repeat (20) @(posedge aclk);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #3000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
